### rtl/pis_pkg.sv
// shared types and constants for the plane inlier scoring core
`timescale 1ns / 1ps
package pis_pkg;
  localparam int FRAC_BITS = 16;
  localparam int MAX_POINTS = 1048576;
  localparam int CNT_W = 21;
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_POINTS);

  localparam logic [2:0] REG_A = 3'd0;
  localparam logic [2:0] REG_B = 3'd1;
  localparam logic [2:0] REG_C = 3'd2;
  localparam logic [2:0] REG_D = 3'd3;
  localparam logic [2:0] REG_THR = 3'd4;

  // controller to datapath commands
  typedef struct packed {
    logic sq_start;    // compute sum of squares
    logic sqrt_start;  // start isqrt
    logic ndiv_start;  // start normalization divide for coef idx
    logic [1:0] ndiv_sel;
    logic run_clear;   // clear run accumulators
    logic point_load;  // take input point
    logic mac_step;    // advance distance pipeline
    logic fin_start;   // start final divisions
    logic out_load;    // load output register
  } pis_cmd_t;

  typedef struct packed {
    logic sqrt_done;
    logic div_done;
    logic fin_done;    // finish step complete, result ready to load
    logic len_zero;
  } pis_sts_t;
endpackage

### rtl/pis_div.sv
// iterative unsigned restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
module pis_div import pis_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] num,
  input  logic [63:0] den,
  output logic [63:0] quo,
  output logic        done
);
  logic [63:0] rem;
  logic [63:0] q;
  logic [6:0]  cnt;
  logic        busy;
  logic [64:0] trial;

  assign trial = {rem, q[63]} - {1'b0, den};
  assign quo = q;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        q    <= num;
        rem  <= '0;
        cnt  <= 7'd64;
      end else if (busy) begin
        if (!trial[64]) begin
          rem <= trial[63:0];
          q   <= {q[62:0], 1'b1};
        end else begin
          rem <= {rem[62:0], q[63]};
          q   <= {q[62:0], 1'b0};
        end
        cnt <= cnt - 7'd1;
        if (cnt == 7'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

### rtl/pis_datapath.sv
// plane normalization, distance, accumulation and output register
`timescale 1ns / 1ps
module pis_datapath import pis_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  pis_cmd_t           cmd,
  output pis_sts_t           sts,
  input  logic signed [31:0] cfg_a,
  input  logic signed [31:0] cfg_b,
  input  logic signed [31:0] cfg_c,
  input  logic signed [31:0] cfg_d,
  input  logic [31:0]        cfg_thr,
  input  logic signed [31:0] in_x,
  input  logic signed [31:0] in_y,
  input  logic signed [31:0] in_z,
  input  logic [19:0]        in_idx,
  input  logic               in_last,
  output logic [19:0]        index_out,
  output logic               is_inlier,
  output logic               run_done,
  output logic [20:0]        inlier_total,
  output logic [16:0]        fitness,
  output logic signed [31:0] mean_distance,
  output logic               model_valid
);
  // normalization
  logic [63:0] sq;
  logic [63:0] len;
  logic [63:0] sq_rem, sq_r, sq_bit;
  logic        sq_busy, sqrt_done;
  logic signed [31:0] up [4];
  logic signed [63:0] sq_aa, sq_bb, sq_cc;

  // shared divider
  logic        div_start;
  logic [63:0] div_num, div_den, div_quo;
  logic        div_done;
  logic        div_neg;
  logic [1:0]  div_sel;
  logic        div_fin;

  assign sq_aa = cfg_a * cfg_a;
  assign sq_bb = cfg_b * cfg_b;
  assign sq_cc = cfg_c * cfg_c;

  always_ff @(posedge clk) begin
    if (cmd.sq_start) begin
      sq <= $unsigned(sq_aa) + $unsigned(sq_bb) + $unsigned(sq_cc);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_busy   <= 1'b0;
      sqrt_done <= 1'b0;
    end else begin
      sqrt_done <= 1'b0;
      if (cmd.sqrt_start) begin
        sq_busy <= 1'b1;
        sq_rem  <= sq;
        sq_r    <= '0;
        sq_bit  <= 64'h4000_0000_0000_0000;
      end else if (sq_busy) begin
        if (sq_rem >= sq_r + sq_bit) begin
          sq_rem <= sq_rem - (sq_r + sq_bit);
          sq_r   <= (sq_r >> 1) + sq_bit;
        end else begin
          sq_r <= sq_r >> 1;
        end
        sq_bit <= sq_bit >> 2;
        if (sq_bit == 64'd1) begin
          sq_busy   <= 1'b0;
          sqrt_done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (sqrt_done) len <= sq_r;
  end

  // distance pipeline
  logic signed [31:0] px, py, pz;
  logic [19:0]        p_idx;
  logic               p_last;
  logic signed [63:0] m0, m1, m2, m3;
  logic signed [63:0] acc, shr;
  logic signed [31:0] point_dist;
  logic [31:0]        mag;
  logic               valid_run;
  logic               inl;
  logic [1:0]         ph;

  logic [CNT_W-1:0]   pts, inls, pts_n, inls_n;
  logic signed [63:0] dsum, dsum_n;
  logic               take;

  assign valid_run = (up[0] != 0) || (up[1] != 0) || (up[2] != 0);

  always_comb begin
    acc = m0 + m1 + m2 + m3;
    shr = acc >>> FRAC_BITS;
    if (shr > 64'sd2147483647) point_dist = 32'sh7fff_ffff;
    else if (shr < -64'sd2147483648) point_dist = 32'sh8000_0000;
    else point_dist = shr[31:0];
    mag = point_dist[31] ? 32'(-point_dist) : 32'(point_dist);
    inl = valid_run && (mag <= cfg_thr);
    take = inl && (inls < MAX_CNT);
    inls_n = take ? inls + 1'b1 : inls;
    dsum_n = take ? dsum + 64'(point_dist) : dsum;
    pts_n = (pts < MAX_CNT) ? pts + 1'b1 : pts;
  end

  always_ff @(posedge clk) begin
    if (cmd.point_load) begin
      px <= in_x; py <= in_y; pz <= in_z;
      p_idx <= in_idx; p_last <= in_last;
    end
    if (cmd.mac_step) begin
      m0 <= px * up[0];
      m1 <= py * up[1];
      m2 <= pz * up[2];
      m3 <= 64'(up[3]) <<< FRAC_BITS;
    end
  end

  // result holding for finish
  logic r_inl;
  logic [CNT_W-1:0] r_inls;
  logic [16:0] r_fit;

  always_ff @(posedge clk) begin
    if (rst) begin
      pts <= '0; inls <= '0; dsum <= '0;
    end else if (cmd.run_clear) begin
      pts <= '0; inls <= '0; dsum <= '0;
    end else if (cmd.fin_start) begin
      pts <= pts_n; inls <= inls_n; dsum <= dsum_n;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fin_start) r_inl <= inl;
  end

  // divider source selection: ndiv_sel 0..3 normalization, ph 1 fitness, ph 2 mean
  always_ff @(posedge clk) begin
    if (rst) begin
      div_start <= 1'b0;
      div_fin   <= 1'b0;
      ph        <= '0;
    end else begin
      div_start <= 1'b0;
      if (cmd.ndiv_start) begin
        div_start <= 1'b1;
        div_fin   <= 1'b0;
        div_sel   <= cmd.ndiv_sel;
        case (cmd.ndiv_sel)
          2'd0: begin div_neg <= cfg_a[31];
            div_num <= 64'(cfg_a[31] ? -64'(cfg_a) : 64'(cfg_a)) << FRAC_BITS; end
          2'd1: begin div_neg <= cfg_b[31];
            div_num <= 64'(cfg_b[31] ? -64'(cfg_b) : 64'(cfg_b)) << FRAC_BITS; end
          2'd2: begin div_neg <= cfg_c[31];
            div_num <= 64'(cfg_c[31] ? -64'(cfg_c) : 64'(cfg_c)) << FRAC_BITS; end
          default: begin div_neg <= cfg_d[31];
            div_num <= 64'(cfg_d[31] ? -64'(cfg_d) : 64'(cfg_d)) << FRAC_BITS; end
        endcase
        div_den <= len;
      end else if (cmd.fin_start) begin
        r_inls <= inls_n;
        if (p_last && inls_n != 0) begin
          div_start <= 1'b1;
          div_fin   <= 1'b1;
          ph        <= 2'd1;
          div_neg   <= 1'b0;
          div_num   <= 64'(inls_n) << 16;
          div_den   <= 64'(pts_n);
        end else begin
          ph <= 2'd3;
        end
      end else if (div_done && div_fin && ph == 2'd1) begin
        r_fit     <= div_quo[16:0];
        div_start <= 1'b1;
        ph        <= 2'd2;
        div_neg   <= dsum[63];
        div_num   <= dsum[63] ? -dsum : dsum;
        div_den   <= 64'(inls);
      end else if (div_done && div_fin && ph == 2'd2) begin
        ph <= 2'd0;
      end else if (ph == 2'd3) begin
        ph <= 2'd0;
      end
    end
  end

  pis_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .num(div_num), .den(div_den),
    .quo(div_quo), .done(div_done)
  );

  logic signed [63:0] sq_signed;
  logic signed [31:0] sat_q;
  always_comb begin
    sq_signed = div_neg ? -$signed(div_quo) : $signed(div_quo);
    if (sq_signed > 64'sd2147483647) sat_q = 32'sh7fff_ffff;
    else if (sq_signed < -64'sd2147483648) sat_q = 32'sh8000_0000;
    else sat_q = sq_signed[31:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.run_clear && sts.len_zero) begin
      up[0] <= '0; up[1] <= '0; up[2] <= '0; up[3] <= '0;
    end else if (div_done && !div_fin) begin
      up[div_sel] <= sat_q;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      index_out    <= p_idx;
      is_inlier    <= r_inl;
      run_done     <= p_last;
      inlier_total <= r_inls;
      model_valid  <= valid_run;
      if (div_fin && ph == 2'd0 && p_last && r_inls != 0) begin
        fitness       <= r_fit;
        mean_distance <= sat_q;
      end else begin
        fitness       <= '0;
        mean_distance <= '0;
      end
    end
  end

  assign sts.sqrt_done = sqrt_done;
  assign sts.div_done  = div_done;
  assign sts.fin_done  = (div_done && div_fin && ph == 2'd2) || (ph == 2'd3);
  assign sts.len_zero  = (len == 64'd0);
endmodule

### rtl/pis_ctrl.sv
// sequencing controller for run start, point scoring and run finish
`timescale 1ns / 1ps
module pis_ctrl import pis_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_fire,
  input  logic     in_last,
  input  logic     out_busy,
  input  logic     out_taken,
  input  pis_sts_t sts,
  output pis_cmd_t cmd,
  output logic     in_ready
);
  typedef enum logic [9:0] {
    S_IDLE = 10'b0000000001,
    S_SQ   = 10'b0000000010,
    S_SQRT = 10'b0000000100,
    S_NDIV = 10'b0000001000,
    S_NWT  = 10'b0000010000,
    S_WAIT = 10'b0000100000,
    S_MAC  = 10'b0001000000,
    S_ACC  = 10'b0010000000,
    S_FIN  = 10'b0100000000,
    S_OUT  = 10'b1000000000
  } state_t;

  state_t state, state_next;
  logic   active, active_next;
  logic [1:0] sel, sel_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE; active <= 1'b0; sel <= '0;
    end else begin
      state <= state_next; active <= active_next; sel <= sel_next;
    end
  end

  always_comb begin
    cmd = '0;
    state_next = state;
    active_next = active;
    sel_next = sel;
    in_ready = 1'b0;
    cmd.ndiv_sel = sel;
    case (state)
      S_IDLE: begin
        // the output register holds a waiting result on its own
        in_ready = 1'b1;
        if (in_fire) begin
          cmd.point_load = 1'b1;
          if (!active) begin
            cmd.sq_start = 1'b1;
            state_next = S_SQ;
          end else begin
            state_next = S_MAC;
          end
          if (in_last) active_next = 1'b0;
          else active_next = 1'b1;
        end
      end
      S_SQ: begin
        cmd.sqrt_start = 1'b1;
        state_next = S_SQRT;
      end
      S_SQRT: if (sts.sqrt_done) state_next = S_WAIT;
      S_WAIT: begin
        sel_next = 2'd0;
        cmd.run_clear = 1'b1;
        state_next = sts.len_zero ? S_MAC : S_NDIV;
      end
      S_NDIV: begin
        cmd.ndiv_start = 1'b1;
        state_next = S_NWT;
      end
      S_NWT: if (sts.div_done) begin
        if (sel == 2'd3) state_next = S_MAC;
        else begin
          sel_next = sel + 2'd1;
          state_next = S_NDIV;
        end
      end
      S_MAC: begin
        cmd.mac_step = 1'b1;
        state_next = S_ACC;
      end
      S_ACC: begin
        cmd.fin_start = 1'b1;
        state_next = S_FIN;
      end
      S_FIN: begin
        // fitness then mean, or a direct pass when nothing to divide
        if (sts.fin_done) state_next = S_OUT;
      end
      S_OUT: if (!out_busy || out_taken) begin
        cmd.out_load = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end
endmodule

### rtl/plane_inlier_scoring_core.sv
// top level of the plane inlier scoring core
//
// usage: write plane_a, plane_b, plane_c, plane_offset and inlier_threshold
// through the cfg channel (index 0..4) while idle, then stream points on the
// input channel. the first point of a run latches the plane: sum of squares,
// a 32-step integer square root and, unless its length is zero, four
// 64-step divides normalize it. each later point passes the MAC, ACC, FIN
// and OUT states to its result, and the next point is taken only once that
// result is loaded. the point flagged last, when it has inliers, also runs
// the fitness and mean divides on the shared 64-step divider. one result
// per point leaves through an output register that holds while the receiver
// stalls; the next point is taken while a result waits, and scoring stalls
// only when a second result would overwrite it. reset (rst, synchronous)
// clears the config registers, totals, the output valid flag and the run
// flag; the plane is renormalized at the start of every run.
`timescale 1ns / 1ps
module plane_inlier_scoring_core import pis_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] point_x,
  input  logic signed [31:0] point_y,
  input  logic signed [31:0] point_z,
  input  logic [19:0]        point_index,
  input  logic               last_point,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [19:0]        index_out,
  output logic               is_inlier,
  output logic               run_done,
  output logic [20:0]        inlier_total,
  output logic [16:0]        fitness,
  output logic signed [31:0] mean_distance,
  output logic               model_valid
);
  logic signed [31:0] reg_a, reg_b, reg_c, reg_d;
  logic [31:0] reg_thr;
  pis_cmd_t cmd;
  pis_sts_t sts;
  logic in_ready, in_fire, out_taken;

  assign cfg_ready = 1'b1;

  // register file transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      reg_a <= '0; reg_b <= '0; reg_c <= '0; reg_d <= '0; reg_thr <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_A:   reg_a <= cfg_data;
        REG_B:   reg_b <= cfg_data;
        REG_C:   reg_c <= cfg_data;
        REG_D:   reg_d <= cfg_data;
        REG_THR: reg_thr <= cfg_data;
        default: ;
      endcase
    end
  end

  assign in_stall  = !in_ready;
  assign in_fire   = in_valid && in_ready;
  assign out_taken = out_valid && !out_stall;

  // output register occupancy
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (cmd.out_load) out_valid <= 1'b1;
    else if (out_taken) out_valid <= 1'b0;
  end

  pis_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_fire(in_fire), .in_last(last_point),
    .out_busy(out_valid), .out_taken(out_taken), .sts(sts), .cmd(cmd),
    .in_ready(in_ready)
  );

  pis_datapath u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .sts(sts),
    .cfg_a(reg_a), .cfg_b(reg_b), .cfg_c(reg_c), .cfg_d(reg_d), .cfg_thr(reg_thr),
    .in_x(point_x), .in_y(point_y), .in_z(point_z), .in_idx(point_index),
    .in_last(last_point),
    .index_out(index_out), .is_inlier(is_inlier), .run_done(run_done),
    .inlier_total(inlier_total), .fitness(fitness), .mean_distance(mean_distance),
    .model_valid(model_valid)
  );
endmodule
